/* hdl/deadline_ordered_task_queue_macros.svh */
// Assertion helpers shared by the task queue RTL.
`ifndef DEADLINE_ORDERED_TASK_QUEUE_MACROS_SVH
`define DEADLINE_ORDERED_TASK_QUEUE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define DOTQ_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define DOTQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define DOTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dotq_pkg.sv */
`default_nettype none

package dotq_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int DL_W        = 32;
    localparam int CMD_W       = 3;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_POP       = 3'd2,
        CMD_SORT      = 3'd3,
        CMD_DELETE    = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0] ident;
        logic [DL_W-1:0] deadline;
    } entry_t;

    // Operands of the shared compare and address unit.
    typedef struct packed {
        logic [DL_W-1:0]  dl_a;
        logic [DL_W-1:0]  dl_b;
        logic [ID_W-1:0]  id_a;
        logic [ID_W-1:0]  id_b;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] offset;
    } alu_req_t;

    typedef struct packed {
        logic             dl_gt;
        logic             id_eq;
        logic [IDX_W-1:0] addr;
    } alu_res_t;

    // Step a physical pointer around the circular storage.
    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(DEPTH - 1)) begin
            r = '0;
        end
        else begin
            r = p + IDX_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/deadline_ordered_task_queue.sv */
// Delete on a non-empty list scans and shifts together, visiting every entry; sort makes
// passes over the list, each one shorter than the last. One transaction is worked at a time
// through one memory port pair. A new input is taken in the cycle after the previous result
// is registered. Reset (rst_n low, asynchronous) empties the list; storage contents are not
// cleared.
`default_nettype none
`include "deadline_ordered_task_queue_macros.svh"

module deadline_ordered_task_queue (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [dotq_pkg::CMD_W-1:0]         command,
    input  wire  [dotq_pkg::ID_W-1:0]          task_ident,
    input  wire  [dotq_pkg::DL_W-1:0]          task_deadline,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               popped_valid,
    output logic [dotq_pkg::ID_W-1:0]          popped_ident,
    output logic [dotq_pkg::DL_W-1:0]          popped_deadline,
    output logic [dotq_pkg::COUNT_OUT_W-1:0]   entry_count,
    output logic [dotq_pkg::STATUS_W-1:0]      status
);
    import dotq_pkg::*;

    // The sequencer walks the list one entry per cycle. Storage is a circular buffer:
    // head_reg is the physical slot of list position 0, so inserts at the front and pops
    // at the head move only the head pointer. Sort and delete stream entries through the
    // registered read port while writing back one slot behind.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_A,
        S_POP_B,
        S_SORT_A,
        S_SORT_B,
        S_SORT_STEP,
        S_SORT_TAIL,
        S_DEL_A,
        S_DEL_SCAN,
        S_DEL_SHIFT,
        S_DONE
    } state_t;

    state_t                 state_reg,     state_next;
    logic [IDX_W-1:0]       head_reg,      head_next;
    logic [CNT_W-1:0]       count_reg,     count_next;
    logic [IDX_W-1:0]       rd_ptr_reg,    rd_ptr_next;
    logic [IDX_W-1:0]       wr_ptr_reg,    wr_ptr_next;
    logic [IDX_W-1:0]       pos_reg,       pos_next;
    logic [CNT_W-1:0]       pass_end_reg,  pass_end_next;
    logic                   swapped_reg,   swapped_next;
    entry_t                 carry_reg,     carry_next;
    cmd_t                   cmd_reg,       cmd_next;
    logic [ID_W-1:0]        ident_reg,     ident_next;
    logic [DL_W-1:0]        dl_reg,        dl_next;
    logic                   res_pv_reg,    res_pv_next;
    logic [ID_W-1:0]        res_pid_reg,   res_pid_next;
    logic [DL_W-1:0]        res_pdl_reg,   res_pdl_next;
    status_t                res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_pv_reg,    out_pv_next;
    logic [ID_W-1:0]        out_pid_reg,   out_pid_next;
    logic [DL_W-1:0]        out_pdl_reg,   out_pdl_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    status_t                out_status_reg, out_status_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    entry_t           mem_rdata;
    alu_req_t         alu_req;
    alu_res_t         alu_res;

    logic [CNT_W:0]   pos_ext;
    logic             list_full;
    logic             list_empty;
    logic             last_cmp;
    logic             last_scan;
    logic             last_shift;

    dotq_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_ptr_reg),
        .rdata (mem_rdata)
    );

    // Shared unit: deadline compare for the sort, identifier match for delete,
    // and the modular address add for inserts and pops.
    dotq_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    always_comb
    begin
        alu_req.dl_a = carry_reg.deadline;
        alu_req.dl_b = mem_rdata.deadline;
        alu_req.id_a = mem_rdata.ident;
        alu_req.id_b = ident_reg;
        alu_req.base = head_reg;
        case (cmd_reg)
            CMD_INS_FRONT: alu_req.offset = IDX_W'(DEPTH - 1);
            CMD_POP:       alu_req.offset = IDX_W'(1);
            default:       alu_req.offset = IDX_W'(count_reg);
        endcase
    end

    assign pos_ext    = {1'b0, CNT_W'(pos_reg)};
    assign list_full  = (count_reg == CNT_W'(DEPTH));
    assign list_empty = (count_reg == '0);
    // The current sort step compares the last pair of this pass.
    assign last_cmp   = ((pos_ext + (CNT_W + 1)'(2)) == {1'b0, pass_end_reg});
    // The entry under the scan is the last one held.
    assign last_scan  = ((pos_ext + (CNT_W + 1)'(1)) == {1'b0, count_reg});
    // This shift write fills the next-to-last slot, closing the gap.
    assign last_shift = ((pos_ext + (CNT_W + 1)'(2)) == {1'b0, count_reg});

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        pos_next        = pos_reg;
        pass_end_next   = pass_end_reg;
        swapped_next    = swapped_reg;
        carry_next      = carry_reg;
        cmd_next        = cmd_reg;
        ident_next      = ident_reg;
        dl_next         = dl_reg;
        res_pv_next     = res_pv_reg;
        res_pid_next    = res_pid_reg;
        res_pdl_next    = res_pdl_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_pv_next     = out_pv_reg;
        out_pid_next    = out_pid_reg;
        out_pdl_next    = out_pdl_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_ptr_reg;
        mem_wdata       = carry_reg;

        // The output register empties when the downstream side takes the transaction.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(command);
                    ident_next = task_ident;
                    dl_next    = task_deadline;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_pv_next     = 1'b0;
                res_pid_next    = '0;
                res_pdl_next    = '0;
                res_status_next = ST_OK;
                state_next      = S_DONE;
                case (cmd_reg)
                    CMD_INS_FRONT:
                    begin
                        if (list_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            // New head is one slot before the old one.
                            mem_we     = 1'b1;
                            mem_waddr  = alu_res.addr;
                            mem_wdata  = '{ident: ident_reg, deadline: dl_reg};
                            head_next  = alu_res.addr;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_INS_BACK:
                    begin
                        if (list_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = alu_res.addr;
                            mem_wdata  = '{ident: ident_reg, deadline: dl_reg};
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (list_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_ptr_next = head_reg;
                            state_next  = S_POP_A;
                        end
                    end
                    CMD_SORT:
                    begin
                        if (count_reg > CNT_W'(1))
                        begin
                            rd_ptr_next   = head_reg;
                            pass_end_next = count_reg;
                            state_next    = S_SORT_A;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (list_empty)
                        begin
                            res_status_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            rd_ptr_next = head_reg;
                            wr_ptr_next = head_reg;
                            pos_next    = '0;
                            state_next  = S_DEL_A;
                        end
                    end
                    default:
                    begin
                        // Unused command codes leave the list alone.
                    end
                endcase
            end

            S_POP_A:
            begin
                state_next = S_POP_B;
            end

            S_POP_B:
            begin
                res_pv_next  = 1'b1;
                res_pid_next = mem_rdata.ident;
                res_pdl_next = mem_rdata.deadline;
                head_next    = alu_res.addr;
                count_next   = count_reg - CNT_W'(1);
                state_next   = S_DONE;
            end

            S_SORT_A:
            begin
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                state_next  = S_SORT_B;
            end

            S_SORT_B:
            begin
                // The first entry becomes the carried element of this pass.
                carry_next   = mem_rdata;
                rd_ptr_next  = ptr_inc(rd_ptr_reg);
                wr_ptr_next  = head_reg;
                pos_next     = '0;
                swapped_next = 1'b0;
                state_next   = S_SORT_STEP;
            end

            S_SORT_STEP:
            begin
                // The larger deadline travels on; ties keep their order.
                mem_we    = 1'b1;
                mem_waddr = wr_ptr_reg;
                if (alu_res.dl_gt)
                begin
                    mem_wdata    = mem_rdata;
                    swapped_next = 1'b1;
                end
                else
                begin
                    mem_wdata  = carry_reg;
                    carry_next = mem_rdata;
                end
                wr_ptr_next = ptr_inc(wr_ptr_reg);
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                pos_next    = pos_reg + IDX_W'(1);
                if (last_cmp)
                begin
                    state_next = S_SORT_TAIL;
                end
            end

            S_SORT_TAIL:
            begin
                mem_we        = 1'b1;
                mem_waddr     = wr_ptr_reg;
                mem_wdata     = carry_reg;
                pass_end_next = pass_end_reg - CNT_W'(1);
                if (swapped_reg && (pass_end_reg > CNT_W'(2)))
                begin
                    rd_ptr_next = head_reg;
                    state_next  = S_SORT_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DEL_A:
            begin
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                state_next  = S_DEL_SCAN;
            end

            S_DEL_SCAN:
            begin
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                if (alu_res.id_eq)
                begin
                    if (last_scan)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DEL_SHIFT;
                    end
                end
                else
                begin
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    pos_next    = pos_reg + IDX_W'(1);
                    if (last_scan)
                    begin
                        res_status_next = ST_NOTFOUND;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DEL_SHIFT:
            begin
                // Entries behind the match move up by one slot.
                mem_we      = 1'b1;
                mem_waddr   = wr_ptr_reg;
                mem_wdata   = mem_rdata;
                wr_ptr_next = ptr_inc(wr_ptr_reg);
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                pos_next    = pos_reg + IDX_W'(1);
                if (last_shift)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_pv_next     = res_pv_reg;
                    out_pid_next    = res_pid_reg;
                    out_pdl_next    = res_pdl_reg;
                    out_count_next  = COUNT_OUT_W'(count_reg);
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pos_reg        <= '0;
            pass_end_reg   <= '0;
            swapped_reg    <= 1'b0;
            carry_reg      <= '0;
            cmd_reg        <= CMD_INS_FRONT;
            ident_reg      <= '0;
            dl_reg         <= '0;
            res_pv_reg     <= 1'b0;
            res_pid_reg    <= '0;
            res_pdl_reg    <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_pv_reg     <= 1'b0;
            out_pid_reg    <= '0;
            out_pdl_reg    <= '0;
            out_count_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            pos_reg        <= pos_next;
            pass_end_reg   <= pass_end_next;
            swapped_reg    <= swapped_next;
            carry_reg      <= carry_next;
            cmd_reg        <= cmd_next;
            ident_reg      <= ident_next;
            dl_reg         <= dl_next;
            res_pv_reg     <= res_pv_next;
            res_pid_reg    <= res_pid_next;
            res_pdl_reg    <= res_pdl_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_pv_reg     <= out_pv_next;
            out_pid_reg    <= out_pid_next;
            out_pdl_reg    <= out_pdl_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign popped_valid    = out_pv_reg;
    assign popped_ident    = out_pid_reg;
    assign popped_deadline = out_pdl_reg;
    assign entry_count     = out_count_reg;
    assign status          = out_status_reg;

    // The held count never passes the storage depth.
    `DOTQ_ASSERT_HOLDS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH),
                       "entry count exceeds depth")
    // A full status is only reported while the list is really full.
    `DOTQ_ASSERT_IMPLIES(a_full_status, clk, rst_n,
                         (state_reg == S_DONE) && (res_status_reg == ST_FULL), list_full,
                         "full status on a list with room")
    // A delivered task always comes with an ok status.
    `DOTQ_ASSERT_IMPLIES(a_pop_status, clk, rst_n, out_valid_reg && out_pv_reg,
                         out_status_reg == ST_OK, "popped task without ok status")
    // A sort step never runs past the end of its pass.
    `DOTQ_ASSERT_NEXT(a_sort_walk, clk, rst_n, (state_reg == S_SORT_STEP) && last_cmp,
                      state_reg == S_SORT_TAIL, "sort pass overran its end")

endmodule

`default_nettype wire

/* hdl/dotq_mem.sv */
`default_nettype none

module dotq_mem (
    input  wire                          clk,
    input  wire                          we,
    input  wire  [dotq_pkg::IDX_W-1:0]   waddr,
    input  dotq_pkg::entry_t             wdata,
    input  wire  [dotq_pkg::IDX_W-1:0]   raddr,
    output dotq_pkg::entry_t             rdata
);
    import dotq_pkg::*;

    entry_t mem_array [DEPTH];
    entry_t rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/dotq_alu.sv */
`default_nettype none

module dotq_alu (
    input  dotq_pkg::alu_req_t req,
    output dotq_pkg::alu_res_t res
);
    import dotq_pkg::*;

    logic [IDX_W:0] sum;
    logic [IDX_W:0] wrapped;

    // Address sum modulo the storage depth; both operands are below DEPTH.
    always_comb
    begin
        sum = {1'b0, req.base} + {1'b0, req.offset};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            wrapped = sum - (IDX_W + 1)'(DEPTH);
        end
        else
        begin
            wrapped = sum;
        end
    end

    assign res.dl_gt = (req.dl_a > req.dl_b);
    assign res.id_eq = (req.id_a == req.id_b);
    assign res.addr  = wrapped[IDX_W-1:0];

endmodule

`default_nettype wire

/* dv/deadline_ordered_task_queue_checker.sv */
`timescale 1ns / 100ps

module deadline_ordered_task_queue_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [dotq_pkg::CMD_W-1:0]       command,
    input  logic [dotq_pkg::ID_W-1:0]        task_ident,
    input  logic [dotq_pkg::DL_W-1:0]        task_deadline,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             popped_valid,
    input  logic [dotq_pkg::ID_W-1:0]        popped_ident,
    input  logic [dotq_pkg::DL_W-1:0]        popped_deadline,
    input  logic [dotq_pkg::COUNT_OUT_W-1:0] entry_count,
    input  logic [dotq_pkg::STATUS_W-1:0]    status,
    output int                               mismatches,
    output int                               outstanding
);
    import dotq_pkg::*;

    typedef struct packed {
        logic                   pv;
        logic [ID_W-1:0]        ident;
        logic [DL_W-1:0]        deadline;
        logic [COUNT_OUT_W-1:0] count;
        status_t                st;
    } reply_t;

    reply_t          expected_replies[$];
    logic [ID_W-1:0] list_idents[DEPTH];
    logic [DL_W-1:0] list_deadlines[DEPTH];
    int              list_len = 0;
    int              fail_total = 0;

    // Close the gap left by the entry at pos, keeping list order.
    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < list_len; i++)
        begin
            list_idents[i]    = list_idents[i + 1];
            list_deadlines[i] = list_deadlines[i + 1];
        end
        list_len--;
    endfunction

    function automatic reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [ID_W-1:0]  ident,
                                             input logic [DL_W-1:0]  deadline);
        reply_t          r;
        int              i;
        int              last;
        bit              swapped;
        bit              found;
        logic [ID_W-1:0] tmp_id;
        logic [DL_W-1:0] tmp_dl;
        r = '0;
        r.st = ST_OK;
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK:
            begin
                if (list_len >= DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else if (cmd == CMD_INS_FRONT)
                begin
                    for (i = list_len; i > 0; i--)
                    begin
                        list_idents[i]    = list_idents[i - 1];
                        list_deadlines[i] = list_deadlines[i - 1];
                    end
                    list_idents[0]    = ident;
                    list_deadlines[0] = deadline;
                    list_len++;
                end
                else
                begin
                    list_idents[list_len]    = ident;
                    list_deadlines[list_len] = deadline;
                    list_len++;
                end
            end
            CMD_POP:
            begin
                if (list_len == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    r.pv       = 1'b1;
                    r.ident    = list_idents[0];
                    r.deadline = list_deadlines[0];
                    drop_entry(0);
                end
            end
            CMD_SORT:
            begin
                // Bubble sort with strict compare, so equal deadlines never swap.
                last    = list_len;
                swapped = 1'b1;
                while (swapped && last > 1)
                begin
                    swapped = 1'b0;
                    for (i = 0; i + 1 < last; i++)
                    begin
                        if (list_deadlines[i] > list_deadlines[i + 1])
                        begin
                            tmp_dl                = list_deadlines[i];
                            list_deadlines[i]     = list_deadlines[i + 1];
                            list_deadlines[i + 1] = tmp_dl;
                            tmp_id                = list_idents[i];
                            list_idents[i]        = list_idents[i + 1];
                            list_idents[i + 1]    = tmp_id;
                            swapped               = 1'b1;
                        end
                    end
                    last--;
                end
            end
            CMD_DELETE:
            begin
                r.st  = ST_NOTFOUND;
                found = 1'b0;
                for (i = 0; i < list_len && !found; i++)
                begin
                    if (list_idents[i] == ident)
                    begin
                        drop_entry(i);
                        found = 1'b1;
                        r.st  = ST_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_OUT_W'(list_len);
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            // Results are checked before the new command is predicted, since the
            // block works one transaction at a time.
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    fail_total++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    fail_total += field_differs("popped_valid", 32'(want.pv), 32'(popped_valid));
                    fail_total += field_differs("popped_ident", want.ident, popped_ident);
                    fail_total += field_differs("popped_deadline", want.deadline,
                                                popped_deadline);
                    fail_total += field_differs("entry_count", 32'(want.count),
                                                32'(entry_count));
                    fail_total += field_differs("status", 32'(want.st), 32'(status));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_replies.push_back(apply_command(command, task_ident, task_deadline));
            end
        end
        mismatches  <= fail_total;
        outstanding <= expected_replies.size();
    end

endmodule

/* dv/deadline_ordered_task_queue_tb.sv */
`timescale 1ns / 100ps

module deadline_ordered_task_queue_tb;
    import dotq_pkg::*;

    // Command codes the block does not define; it must ignore them.
    localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

    // Queue fill tendencies for stretches of random commands.
    localparam int BIAS_FILL     = 0;
    localparam int BIAS_DRAIN    = 1;
    localparam int BIAS_BALANCED = 2;

    localparam int QUEUE_ITEMS  = 1250;
    localparam int BIAS_SPAN    = 40;
    // Watchdog limit for a stretch with no transaction; the longest sort stays well below it.
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [CMD_W-1:0]       command = '0;
    logic [ID_W-1:0]        task_ident = '0;
    logic [DL_W-1:0]        task_deadline = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   popped_valid;
    logic [ID_W-1:0]        popped_ident;
    logic [DL_W-1:0]        popped_deadline;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [STATUS_W-1:0]    status;

    int              mismatches;
    int              outstanding;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              quiet_cycles = 0;
    // Identifiers inserted recently, so that most deletes hit a live entry.
    logic [ID_W-1:0] recent_idents[$];

    deadline_ordered_task_queue u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .task_ident      (task_ident),
        .task_deadline   (task_deadline),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .popped_valid    (popped_valid),
        .popped_ident    (popped_ident),
        .popped_deadline (popped_deadline),
        .entry_count     (entry_count),
        .status          (status)
    );

    deadline_ordered_task_queue_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .task_ident      (task_ident),
        .task_deadline   (task_deadline),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .popped_valid    (popped_valid),
        .popped_ident    (popped_ident),
        .popped_deadline (popped_deadline),
        .entry_count     (entry_count),
        .status          (status),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always #5 clk = ~clk;

    // The receiver drops ready at random with the current stall rate.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: the run is declared hung if no transaction moves on either
    // channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one command and returns at the edge where it is accepted. Valid
    // stays high into the next command unless an idle gap is drawn, so each
    // step sees at most one assignment to in_valid.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] ident,
                                input logic [DL_W-1:0] deadline);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        task_ident    <= ident;
        task_deadline <= deadline;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK)
        begin
            recent_idents.push_back(ident);
            if (recent_idents.size() > 32)
            begin
                void'(recent_idents.pop_front());
            end
        end
    endtask

    // Holds off the sender until every result of the commands so far has
    // been taken. The first wait covers the checker's registered count.
    task automatic await_quiet_queue();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    // Identifiers come from a narrow range half of the time, so duplicates
    // exist and a delete must take the first match.
    function automatic logic [ID_W-1:0] pick_ident();
        if ($urandom_range(1) == 0)
        begin
            return ID_W'($urandom_range(15));
        end
        return $urandom;
    endfunction

    // Deadlines cluster on a few small values so ties are frequent, which
    // exercises the stability of the sort; both extremes show up too.
    function automatic logic [DL_W-1:0] pick_deadline();
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return $urandom;
        end
        else if (r < 80)
        begin
            return DL_W'($urandom_range(7));
        end
        else if (r < 90)
        begin
            return '0;
        end
        return '1;
    endfunction

    // One random command; counted is low for reserved codes, which the block
    // only ignores.
    task automatic send_random(input int bias, output bit counted);
        int               r;
        int               ins_pct;
        int               pop_pct;
        int               sort_pct;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  ident;
        case (bias)
            BIAS_FILL:
            begin
                ins_pct  = 65;
                pop_pct  = 15;
                sort_pct = 8;
            end
            BIAS_DRAIN:
            begin
                ins_pct  = 20;
                pop_pct  = 55;
                sort_pct = 8;
            end
            default:
            begin
                ins_pct  = 40;
                pop_pct  = 30;
                sort_pct = 10;
            end
        endcase
        ident = pick_ident();
        r     = $urandom_range(99);
        if ($urandom_range(99) < 3)
        begin
            cmd = CMD_W'($urandom_range(int'(CMD_RESERVED_HI), int'(CMD_RESERVED_LO)));
        end
        else if (r < ins_pct)
        begin
            cmd = ($urandom_range(1) == 0) ? CMD_INS_FRONT : CMD_INS_BACK;
        end
        else if (r < ins_pct + pop_pct)
        begin
            cmd = CMD_POP;
        end
        else if (r < ins_pct + pop_pct + sort_pct)
        begin
            cmd = CMD_SORT;
        end
        else
        begin
            cmd = CMD_DELETE;
            if (recent_idents.size() > 0 && $urandom_range(99) < 70)
            begin
                ident = recent_idents[$urandom_range(recent_idents.size() - 1)];
            end
        end
        counted = (cmd < CMD_RESERVED_LO);
        send_command(cmd, ident, pick_deadline());
    endtask

    initial
    begin
        int phase;
        int sent;
        int bias;
        int i;
        bit counted;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 14;
        recv_stall_pct = 64;

        // Directed part: commands on an empty list, reserved codes, a one-entry
        // sort, a fill to capacity with ties and extreme values, both inserts
        // into a full list, then sort, a missed and a hit delete, and a pop.
        send_command(CMD_POP, '1, '1);
        send_command(CMD_DELETE, 32'h0000_0000, '0);
        send_command(CMD_SORT, '0, '0);
        send_command(CMD_RESERVED_LO, '1, '1);
        send_command(CMD_RESERVED_HI, 32'h5A5A_A5A5, 32'hA5A5_5A5A);
        send_command(CMD_INS_BACK, 32'h0000_0000, '0);
        send_command(CMD_SORT, '0, '0);
        for (i = 1; i < DEPTH; i++)
        begin
            send_command((i % 2 == 0) ? CMD_INS_FRONT : CMD_INS_BACK,
                         (i == DEPTH - 1) ? '1 : ID_W'(i) * 32'h1111_1111,
                         (i % 3 == 0) ? '1 : ((i % 3 == 1) ? 32'd7 : 32'h8000_0000));
        end
        send_command(CMD_INS_FRONT, 32'hDEAD_0001, 32'd1);
        send_command(CMD_INS_BACK, 32'hDEAD_0002, 32'd2);
        send_command(CMD_SORT, '0, '0);
        send_command(CMD_DELETE, 32'h1234_5678, '0);
        send_command(CMD_DELETE, 32'h3333_3333, '0);
        send_command(CMD_POP, '0, '0);
        await_quiet_queue();

        // Random part in three stretches: sender idle lightly with a busy
        // receiver, then the reverse, then full rate on both sides. The sender
        // waits for the queue to go quiet at the end of each stretch.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 64;
                end
                1:
                begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 14;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            sent = 0;
            bias = BIAS_BALANCED;
            while (sent < QUEUE_ITEMS / 3)
            begin
                if (sent % BIAS_SPAN == 0)
                begin
                    bias = $urandom_range(BIAS_BALANCED, BIAS_FILL);
                end
                send_random(bias, counted);
                if (counted)
                begin
                    sent++;
                end
            end
            await_quiet_queue();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/dotq_pkg.sv
hdl/dotq_mem.sv
hdl/dotq_alu.sv
hdl/deadline_ordered_task_queue.sv
dv/deadline_ordered_task_queue_checker.sv
dv/deadline_ordered_task_queue_tb.sv
